[hdl/gbn_pkg.sv]
package gbn_pkg;

    localparam int BUFFER_DEPTH  = 16384;
    localparam int SLOT_W        = $clog2(BUFFER_DEPTH);

    localparam int SEQ_W         = 32;
    localparam int WIN_W         = 11;
    localparam int TIMER_W       = 16;
    localparam int STORE_INDEX_W = 14;

    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 16;

    localparam int S_TDATA_W     = 40;
    localparam int S_TUSER_W     = 2;
    localparam int M_TDATA_W     = 48;
    localparam int M_TUSER_W     = 3;

    localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST = WIN_W'(100);
    localparam logic [TIMER_W-1:0] TIMEOUT_RST     = TIMER_W'(200);

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    localparam t_cfg_index CFG_WINDOW_SIZE   = CFG_INDEX_W'(0);
    localparam t_cfg_index CFG_TIMEOUT_TICKS = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_DATA  = 2'd1,
        MODE_TICK  = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode            mode;
        logic [SEQ_W-1:0] seq;
        logic             is_file;
        logic             is_end;
        logic             checksum_ok;
    } t_item;

    typedef struct packed {
        logic                     ack_valid;
        logic [SEQ_W-1:0]         ack_number;
        logic                     store_valid;
        logic [STORE_INDEX_W-1:0] store_index;
        logic                     file_done;
        logic                     out_of_order;
    } t_result;

    typedef struct packed {
        logic [WIN_W-1:0]   window_size;
        logic [TIMER_W-1:0] timeout_ticks;
    } t_cfg;

endpackage

[hdl/gbn_cfg.sv]
module gbn_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  gbn_pkg::t_cfg_index          i_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] i_data,
    output logic                         o_ready,
    output gbn_pkg::t_cfg                o_cfg
);
    import gbn_pkg::*;

    logic [WIN_W-1:0]   r_window_size;
    logic [TIMER_W-1:0] r_timeout_ticks;

    assign o_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size   <= WINDOW_SIZE_RST;
            r_timeout_ticks <= TIMEOUT_RST;
        end else if (i_valid) begin
            unique case (i_index)
                CFG_WINDOW_SIZE:   r_window_size   <= i_data[WIN_W-1:0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.window_size   = r_window_size;
    assign o_cfg.timeout_ticks = r_timeout_ticks;

endmodule

[hdl/gbn_core.sv]
module gbn_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  gbn_pkg::t_item   i_item,
    input  gbn_pkg::t_cfg    i_cfg,
    output gbn_pkg::t_result o_result
);
    import gbn_pkg::*;

    logic               r_active,  n_active;
    logic [SEQ_W-1:0]   r_exp,     n_exp;
    logic [SEQ_W-1:0]   r_win_end, n_win_end;
    logic               r_resync,  n_resync;
    logic [TIMER_W-1:0] r_timer,   n_timer;

    logic [SEQ_W-1:0]   ws_ext;
    logic [SEQ_W-1:0]   exp_inc;
    logic [SEQ_W-1:0]   seq_inc;
    logic [TIMER_W:0]   timer_inc;
    t_result            res;

    assign ws_ext    = SEQ_W'(i_cfg.window_size);
    assign exp_inc   = r_exp + SEQ_W'(1);
    assign seq_inc   = i_item.seq + SEQ_W'(1);
    assign timer_inc = {1'b0, r_timer} + (TIMER_W+1)'(1);

    always_comb begin
        n_active  = r_active;
        n_exp     = r_exp;
        n_win_end = r_win_end;
        n_resync  = r_resync;
        n_timer   = r_timer;
        res       = '0;
        case (i_item.mode)
            MODE_START: begin
                if (i_item.checksum_ok) begin
                    n_active       = 1'b1;
                    n_exp          = seq_inc;
                    n_win_end      = seq_inc + ws_ext;
                    n_resync       = 1'b1;
                    n_timer        = '0;
                    res.ack_valid  = 1'b1;
                    res.ack_number = seq_inc;
                end
            end
            MODE_DATA: begin
                if (i_item.checksum_ok && r_active && i_item.is_file) begin
                    if (i_item.seq == r_exp) begin
                        res.store_valid = 1'b1;
                        res.store_index = STORE_INDEX_W'(i_item.seq[SLOT_W-1:0]);
                        n_resync        = 1'b1;
                        n_exp           = exp_inc;
                        if (i_item.is_end) begin
                            n_win_end      = exp_inc;
                            res.ack_valid  = 1'b1;
                            res.ack_number = exp_inc;
                            res.file_done  = 1'b1;
                            n_active       = 1'b0;
                        end else if (exp_inc == r_win_end) begin
                            // window full: cumulative ack and slide
                            n_win_end      = exp_inc + ws_ext;
                            res.ack_valid  = 1'b1;
                            res.ack_number = exp_inc;
                            n_timer        = '0;
                        end
                    end else if (i_item.seq > r_exp) begin
                        res.out_of_order = 1'b1;
                        if (r_resync) begin
                            n_resync       = 1'b0;
                            n_win_end      = r_exp + ws_ext;
                            res.ack_valid  = 1'b1;
                            res.ack_number = r_exp;
                            n_timer        = '0;
                        end
                    end
                end
            end
            MODE_TICK: begin
                if (r_active) begin
                    if (timer_inc > {1'b0, i_cfg.timeout_ticks}) begin
                        n_win_end      = r_exp + ws_ext;
                        res.ack_valid  = 1'b1;
                        res.ack_number = r_exp;
                        n_timer        = '0;
                    end else begin
                        n_timer = timer_inc[TIMER_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_exp     <= '0;
            r_win_end <= '0;
            r_resync  <= 1'b1;
            r_timer   <= '0;
        end else if (i_fire) begin
            r_active  <= n_active;
            r_exp     <= n_exp;
            r_win_end <= n_win_end;
            r_resync  <= n_resync;
            r_timer   <= n_timer;
        end
    end

    assign o_result = res;

endmodule

[hdl/go_back_n_receiver_window_top.sv]
// an accepted request is first held in the input register, then moves into the result
// register, from which its result is offered on the output
// throughput: one request per cycle while the output is not stalled, bounded by the single
// compare-and-update pass on the window registers between input and result register
// reset (synchronous, active low) empties both registers, idles the receiver
// and restores window_size 100 and timeout_ticks 200
module go_back_n_receiver_window_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // seq[31:0], is_file[32], checksum_ok[33], zero pad
    input  logic [gbn_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode[1:0]
    input  logic [gbn_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // ack_number[31:0], store_index[45:32], zero pad
    output logic [gbn_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // ack_valid[0], store_valid[1], out_of_order[2]
    output logic [gbn_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gbn_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gbn_pkg::*;

    logic    r_in_vld;
    t_item   r_in_item;
    logic    r_out_vld;
    t_result r_out_res;
    logic    move;
    t_cfg    cfg;
    t_result core_res;

    gbn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_ready (o_cfg_ready),
        .o_cfg   (cfg)
    );

    gbn_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (move),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    // request moves into the result register when that slot is free or drains
    assign move          = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.mode        <= t_mode'(s_axis_tuser);
            r_in_item.seq         <= s_axis_tdata[SEQ_W-1:0];
            r_in_item.is_file     <= s_axis_tdata[SEQ_W];
            r_in_item.checksum_ok <= s_axis_tdata[SEQ_W+1];
            r_in_item.is_end      <= s_axis_tlast;
        end
        if (move) begin
            r_out_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = M_TDATA_W'({r_out_res.store_index, r_out_res.ack_number});
    assign m_axis_tuser  = {r_out_res.out_of_order, r_out_res.store_valid,
                            r_out_res.ack_valid};
    assign m_axis_tlast  = r_out_res.file_done;

endmodule

[hdl/gbn_chk.sv]
module gbn_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [gbn_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [gbn_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input logic                          m_axis_tlast
);
    import gbn_pkg::*;

    // a stalled result keeps its contents
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // end of file always stores the packet and acks it
    a_done_acks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] && m_axis_tuser[1])
        else $error("file done without ack and store");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser[0] || m_axis_tdata[SEQ_W-1:0] == '0)
            && (m_axis_tuser[1] || m_axis_tdata[SEQ_W+STORE_INDEX_W-1:SEQ_W] == '0))
        else $error("field set without its flag");

    a_ooo_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[2] && m_axis_tuser[1]))
        else $error("out of order packet marked for storage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind go_back_n_receiver_window_top gbn_chk u_gbn_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[test/gbn_window_checker.sv]
module gbn_window_checker
    import gbn_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [S_TDATA_W-1:0]   i_s_tdata,
    input  logic [S_TUSER_W-1:0]   i_s_tuser,
    input  logic                   i_s_tlast,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [M_TDATA_W-1:0]   i_m_tdata,
    input  logic [M_TUSER_W-1:0]   i_m_tuser,
    input  logic                   i_m_tlast,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  t_cfg_index             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_acks,
    output int                     o_stores,
    output int                     o_files_done
);

    // receiver state as seen from the link
    logic               rx_armed;
    logic [SEQ_W-1:0]   next_seq;
    logic [SEQ_W-1:0]   win_edge;
    logic               resync_ok;
    logic [TIMER_W-1:0] tick_count;
    logic [WIN_W-1:0]   cfg_window;
    logic [TIMER_W-1:0] cfg_timeout;

    t_result awaited_responses[$];

    function automatic t_result advance_window(input logic [1:0] mode,
                                               input logic [SEQ_W-1:0] seq,
                                               input logic file_flag,
                                               input logic end_flag,
                                               input logic crc_ok);
        t_result            r;
        logic [TIMER_W:0]   tick_next;
        r = '0;
        if (mode == MODE_START && crc_ok) begin
            rx_armed     = 1'b1;
            next_seq     = seq + 32'd1;
            win_edge     = next_seq + 32'(cfg_window);
            resync_ok    = 1'b1;
            tick_count   = '0;
            r.ack_valid  = 1'b1;
            r.ack_number = next_seq;
        end else if (mode == MODE_DATA && crc_ok && rx_armed && file_flag) begin
            if (seq == next_seq) begin
                r.store_valid = 1'b1;
                r.store_index = STORE_INDEX_W'(seq % BUFFER_DEPTH);
                resync_ok     = 1'b1;
                next_seq      = next_seq + 32'd1;
                if (end_flag) begin
                    win_edge     = next_seq;
                    r.ack_valid  = 1'b1;
                    r.ack_number = next_seq;
                    r.file_done  = 1'b1;
                    rx_armed     = 1'b0;
                end else if (next_seq == win_edge) begin
                    // window full: cumulative ack and slide
                    win_edge     = next_seq + 32'(cfg_window);
                    r.ack_valid  = 1'b1;
                    r.ack_number = next_seq;
                    tick_count   = '0;
                end
            end else if (seq > next_seq) begin
                r.out_of_order = 1'b1;
                if (resync_ok) begin
                    resync_ok    = 1'b0;
                    win_edge     = next_seq + 32'(cfg_window);
                    r.ack_valid  = 1'b1;
                    r.ack_number = next_seq;
                    tick_count   = '0;
                end
            end
        end else if (mode == MODE_TICK && rx_armed) begin
            tick_next = {1'b0, tick_count} + 17'd1;
            if (tick_next > {1'b0, cfg_timeout}) begin
                win_edge     = next_seq + 32'(cfg_window);
                r.ack_valid  = 1'b1;
                r.ack_number = next_seq;
                tick_count   = '0;
            end else begin
                tick_count = tick_next[TIMER_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [SEQ_W-1:0] want,
                                        input logic [SEQ_W-1:0] got);
        if (want !== got) begin
            $error("response field %s: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            rx_armed    = 1'b0;
            next_seq    = '0;
            win_edge    = '0;
            resync_ok   = 1'b1;
            tick_count  = '0;
            cfg_window  = WINDOW_SIZE_RST;
            cfg_timeout = TIMEOUT_RST;
            awaited_responses.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.ack_valid    = i_m_tuser[0];
                got.store_valid  = i_m_tuser[1];
                got.out_of_order = i_m_tuser[2];
                got.ack_number   = i_m_tdata[31:0];
                got.store_index  = i_m_tdata[45:32];
                got.file_done    = i_m_tlast;
                if (awaited_responses.size() == 0) begin
                    $error("response with none outstanding: tdata %0h tuser %0h",
                           i_m_tdata, i_m_tuser);
                    o_fail_count++;
                end else begin
                    want = awaited_responses.pop_front();
                    check_field("ack_valid", 32'(want.ack_valid), 32'(got.ack_valid));
                    check_field("ack_number", want.ack_number, got.ack_number);
                    check_field("store_valid", 32'(want.store_valid), 32'(got.store_valid));
                    check_field("store_index", 32'(want.store_index), 32'(got.store_index));
                    check_field("file_done", 32'(want.file_done), 32'(got.file_done));
                    check_field("out_of_order", 32'(want.out_of_order),
                                32'(got.out_of_order));
                    o_acks       += int'(got.ack_valid);
                    o_stores     += int'(got.store_valid);
                    o_files_done += int'(got.file_done);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_WINDOW_SIZE) begin
                    cfg_window = i_cfg_data[WIN_W-1:0];
                end else if (i_cfg_index == CFG_TIMEOUT_TICKS) begin
                    cfg_timeout = i_cfg_data[TIMER_W-1:0];
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_responses.push_back(advance_window(i_s_tuser, i_s_tdata[31:0],
                                                           i_s_tdata[32], i_s_tlast,
                                                           i_s_tdata[33]));
            end
        end
        o_pending = awaited_responses.size();
    end

endmodule

[test/tb_top.sv]
module tb_top;
    import gbn_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 170;
    localparam int NUM_PHASES   = 8;

    typedef enum int {
        RX_EAGER,
        RX_COIN,
        RX_SLOW
    } t_rx_pace;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [S_TDATA_W-1:0]  s_data    = '0;
    logic [S_TUSER_W-1:0]  s_user    = '0;
    logic                  s_last    = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [M_TDATA_W-1:0]  m_data;
    logic [M_TUSER_W-1:0]  m_user;
    logic                  m_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    t_cfg_index            cfg_index = CFG_WINDOW_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fails;
    int pending;
    int acks;
    int stores;
    int files_done;

    int         cycle_count = 0;
    int         sent_items  = 0;
    int         counted     = 0;
    int         cfg_writes  = 0;
    int         burst_left  = 0;
    logic       no_gaps     = 1'b0;
    logic       hold_req    = 1'b0;
    logic       tx_armed    = 1'b0;
    logic [31:0] tx_next    = '0;
    int         run_left    = 0;

    // receiver pacing, owned by its own process
    int         hold_left   = 0;
    logic       hold_taken  = 1'b0;
    int         pace_left   = 0;
    t_rx_pace   pace        = RX_EAGER;

    go_back_n_receiver_window_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    gbn_window_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_s_tlast    (s_last),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tuser    (m_user),
        .i_m_tlast    (m_last),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_acks       (acks),
        .o_stores     (stores),
        .o_files_done (files_done)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_req && !hold_taken) begin
            // long hold-off so the block backs up and stalls its input
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            m_ready   <= 1'b0;
        end else begin
            if (pace_left == 0) begin
                pace_left = $urandom_range(32, 256);
                pace      = t_rx_pace'($urandom_range(0, 2));
            end
            pace_left--;
            case (pace)
                RX_EAGER: m_ready <= 1'b1;
                RX_COIN:  m_ready <= 1'($urandom_range(0, 1));
                default:  m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // called at a rising edge; returns at the edge where the request is taken
    task automatic offer(input logic [1:0] mode, input logic [31:0] seq,
                         input logic file_flag, input logic end_flag, input logic crc_ok);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        if (no_gaps) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= mode;
        s_last  <= end_flag;
        s_data  <= S_TDATA_W'({crc_ok, file_flag, seq});
        do @(posedge clk); while (!s_ready);
        sent_items++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] win_word,
                            input logic [CFG_DATA_W-1:0] tmo_word);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WINDOW_SIZE;
        cfg_data  <= win_word;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_data  <= tmo_word;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes += 2;
    endtask

    task automatic start_session();
        logic [31:0] base;
        base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 60))
                                           : 32'($urandom);
        offer(MODE_START, base, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
        tx_next  = base + 32'd1;
        run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 40);
        tx_armed = 1'b1;
    endtask

    task automatic random_item();
        int          pick;
        logic        end_flag;
        logic [31:0] seq;
        pick = $urandom_range(0, 99);
        if (!tx_armed) begin
            if (pick < 15) begin
                // traffic while idle is dropped
                offer(($urandom_range(0, 1) != 0) ? MODE_DATA : MODE_TICK, 32'($urandom),
                      1'b1, 1'($urandom_range(0, 1)), 1'b1);
            end else begin
                start_session();
                counted++;
            end
        end else if (pick < 70 || pick >= 97) begin
            run_left--;
            end_flag = (run_left <= 0);
            offer(MODE_DATA, tx_next, 1'b1, end_flag, 1'b1);
            tx_next++;
            if (end_flag) tx_armed = 1'b0;
            counted++;
        end else if (pick < 78) begin
            offer(MODE_TICK, 32'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            counted++;
        end else if (pick < 83) begin
            seq = (pick[0]) ? tx_next + 32'($urandom_range(1, 16)) : 32'($urandom);
            offer(MODE_DATA, seq, 1'b1, 1'($urandom_range(0, 1)), 1'b1);
            counted++;
        end else if (pick < 87) begin
            offer(MODE_DATA, tx_next - 32'($urandom_range(1, 8)), 1'b1,
                  1'($urandom_range(0, 1)), 1'b1);
            counted++;
        end else if (pick < 90) begin
            offer(2'($urandom_range(0, 3)), tx_next, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0);
        end else if (pick < 93) begin
            offer(MODE_DATA, tx_next, 1'b0, 1'($urandom_range(0, 1)), 1'b1);
        end else if (pick < 95) begin
            offer(MODE_UNUSED, 32'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
            start_session();
            counted++;
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] win_words [NUM_PHASES];
        logic [CFG_DATA_W-1:0] tmo_words [NUM_PHASES];
        int phase_end;

        win_words = '{16'd100, 16'd4, 16'd1024, 16'hFFFF, 16'd1, 16'hF800,
                      16'($urandom_range(1, 16)), 16'($urandom_range(1, 64))};
        tmo_words = '{16'd200, 16'd6, 16'd65535, 16'd3, 16'd1, 16'd0,
                      16'($urandom_range(1, 20)), 16'($urandom_range(1, 40))};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // idle receiver ignores everything but a good start request
        offer(MODE_DATA, 32'd0, 1'b1, 1'b0, 1'b1);
        offer(MODE_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        offer(MODE_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        offer(MODE_START, 32'd5, 1'b1, 1'b0, 1'b0);
        // start at the top of the sequence space wraps the expected number
        offer(MODE_START, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
        offer(MODE_DATA, 32'd0, 1'b1, 1'b0, 1'b1);
        offer(MODE_DATA, 32'd1, 1'b0, 1'b0, 1'b1);
        offer(MODE_DATA, 32'd1, 1'b1, 1'b0, 1'b0);
        offer(MODE_DATA, 32'd5, 1'b1, 1'b0, 1'b1);
        offer(MODE_DATA, 32'd6, 1'b1, 1'b0, 1'b1);
        offer(MODE_DATA, 32'd0, 1'b1, 1'b0, 1'b1);
        offer(MODE_DATA, 32'd1, 1'b1, 1'b0, 1'b1);
        offer(MODE_DATA, 32'd9, 1'b1, 1'b0, 1'b1);
        // re-arm while active; highest store slot, then close the file
        offer(MODE_START, 32'h0000_3FFE, 1'b1, 1'b1, 1'b1);
        offer(MODE_DATA, 32'h0000_3FFF, 1'b1, 1'b0, 1'b1);
        offer(MODE_DATA, 32'h0000_4000, 1'b1, 1'b1, 1'b1);
        offer(MODE_DATA, 32'h0000_4001, 1'b1, 1'b0, 1'b1);
        settle();

        // single-packet window and a timeout that fires on every tick
        set_regs(16'd1, 16'd0);
        offer(MODE_START, 32'd10, 1'b1, 1'b0, 1'b1);
        offer(MODE_DATA, 32'd11, 1'b1, 1'b0, 1'b1);
        offer(MODE_TICK, 32'd0, 1'b0, 1'b0, 1'b0);
        offer(MODE_TICK, 32'd0, 1'b0, 1'b0, 1'b1);
        settle();

        // zero window: no fill until the sequence wraps; late compare ignores wrap
        set_regs(16'hF800, 16'd2);
        offer(MODE_START, 32'hFFFF_FFFD, 1'b1, 1'b0, 1'b1);
        offer(MODE_DATA, 32'hFFFF_FFFE, 1'b1, 1'b0, 1'b1);
        offer(MODE_TICK, 32'd0, 1'b0, 1'b0, 1'b1);
        offer(MODE_TICK, 32'd0, 1'b0, 1'b0, 1'b1);
        offer(MODE_TICK, 32'd0, 1'b0, 1'b0, 1'b1);
        offer(MODE_DATA, 32'd0, 1'b1, 1'b0, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            set_regs(win_words[p], tmo_words[p]);
            no_gaps = (p == 1);
            if (p == 1) hold_req <= 1'b1;
            phase_end = counted + PHASE_ITEMS;
            while (counted < phase_end) random_item();
        end
        no_gaps = 1'b0;
        settle();

        $display("summary: %0d requests sent, %0d in the random part, %0d register writes",
                 sent_items, counted, cfg_writes);
        $display("summary: %0d acks, %0d stores, %0d files closed, %0d-cycle output hold",
                 acks, stores, files_done, HOLD_CYCLES);
        if (fails == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
